/* design/bank_record_endian_swapper_defines.svh */
// Assertion macros for the record endian swapper.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BANK_RECORD_ENDIAN_SWAPPER_DEFINES_SVH
`define BANK_RECORD_ENDIAN_SWAPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRES_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bres check failed");
`define BRES_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bres forbidden condition");
`else
`define BRES_ASSERT_IMPL(label, clk, rst_n, prop)
`define BRES_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* design/bres_pkg.sv */
// Shared types and codes for the record endian swapper.
// No dependencies.
package bres_pkg;

    typedef logic [31:0] t_word;
    typedef logic [1:0]  t_phase;
    typedef logic [3:0]  t_hpos;

    localparam t_phase PH_REC  = 2'd0;
    localparam t_phase PH_BANK = 2'd1;
    localparam t_phase PH_DATA = 2'd2;

    typedef struct packed {
        t_word word_out;
        logic  record_last;
        logic  in_header;
    } t_result;

    typedef struct packed {
        t_phase phase;
        t_hpos  hpos;
    } t_core_stat;

endpackage

/* design/bres_in_if.sv */
// Input channel of the record endian swapper: one stream word per transaction.
// Depends on bres_pkg.
interface bres_in_if;
    logic              valid;
    logic              ready;
    bres_pkg::t_word   word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);
endinterface

/* design/bres_out_if.sv */
// Output channel of the record endian swapper: one converted word per transaction.
// Depends on bres_pkg.
interface bres_out_if;
    logic              valid;
    logic              ready;
    bres_pkg::t_word   word_out;
    logic              record_last;
    logic              in_header;

    modport source (output valid, output word_out, output record_last,
                    output in_header, input ready);
    modport sink   (input valid, input word_out, input record_last,
                    input in_header, output ready);
endinterface

/* design/bank_record_endian_swapper.sv */
// Record endian swapper top level: input register, parser/converter, result register.
// A transaction passes through the input register and then the result register.
// Throughput: one word per cycle unless output back-pressure stalls both stages.
// Reset (synchronous, active low) clears the parse state and both stage valids,
// and loads the format tag with 0x20363142; no clearing pass is needed.
`include "bank_record_endian_swapper_defines.svh"
module bank_record_endian_swapper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bres_in_if.sink           i_in,
    bres_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  bres_pkg::t_word   i_cfg_wdata
);
    import bres_pkg::*;

    logic       in_valid;
    t_word      in_word;
    logic       adv;
    logic       fire;
    t_result    res;
    t_core_stat stat;

    assign fire = in_valid && adv;

    bres_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    bres_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_word      (in_word),
        .o_res       (res),
        .o_stat      (stat)
    );

    bres_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_res   (res),
        .o_adv   (adv),
        .o_out   (o_out)
    );

    `BRES_ASSERT_IMPL(a_in_hold, i_clk, i_rst_n, (in_valid && !adv) |=> in_valid)
    `BRES_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid |-> i_in.ready)
    `BRES_ASSERT_NEVER(a_data_pos_zero, i_clk, i_rst_n, stat.phase == PH_DATA && stat.hpos != '0)
endmodule

/* design/bres_in_stage.sv */
// Input register of the record endian swapper.
// Depends on bres_pkg and bres_in_if.
module bres_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bres_in_if.sink             i_in,
    input  logic                i_adv,
    output logic                o_valid,
    output bres_pkg::t_word     o_word
);
    import bres_pkg::*;

    logic  r_valid;
    t_word r_word;
    logic  accept;

    assign i_in.ready = !r_valid || i_adv;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_in.word_in;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
endmodule

/* design/bres_core.sv */
// Record/bank parser and byte-order conversion for the record endian swapper.
// Holds the parse state and the format tag register; depends on bres_pkg.
module bres_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  bres_pkg::t_word       i_cfg_wdata,
    input  logic                  i_fire,
    input  bres_pkg::t_word       i_word,
    output bres_pkg::t_result     o_res,
    output bres_pkg::t_core_stat  o_stat
);
    import bres_pkg::*;

    localparam int unsigned RECORD_HEADER_WORDS = 11;
    localparam int unsigned BANK_HEADER_WORDS   = 10;
    localparam t_hpos REC_POS_SIG    = 4'd1;
    localparam t_hpos REC_POS_NAME0  = 4'd3;
    localparam t_hpos REC_POS_NAME1  = 4'd4;
    localparam t_hpos REC_POS_LAST   = t_hpos'(RECORD_HEADER_WORDS - 1);
    localparam t_hpos BANK_POS_NAME0 = 4'd1;
    localparam t_hpos BANK_POS_NAME1 = 4'd2;
    localparam t_hpos BANK_POS_LEN   = 4'd8;
    localparam t_hpos BANK_POS_LAST  = t_hpos'(BANK_HEADER_WORDS - 1);
    localparam t_word TAG_RESET      = 32'h2036_3142;
    localparam t_word SIGNATURE      = 32'd24;

    function automatic t_word rev32(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic t_word rev16pair(input t_word x);
        return {x[23:16], x[31:24], x[7:0], x[15:8]};
    endfunction

    t_word  r_tag;
    t_phase r_phase, n_phase;
    t_hpos  r_hpos, n_hpos;
    t_word  r_rec_len, n_rec_len;
    t_word  r_wc, n_wc;
    t_word  r_rem, n_rem;
    logic   r_short, n_short;
    t_result res;
    t_word  rem_dec;

    always_comb begin
        n_phase   = r_phase;
        n_hpos    = r_hpos;
        n_rec_len = r_rec_len;
        n_wc      = r_wc;
        n_rem     = r_rem;
        n_short   = r_short;
        res       = '0;
        rem_dec   = (r_rem != '0) ? r_rem - 32'd1 : '0;
        unique case (r_phase)
            PH_BANK: begin
                res.in_header = 1'b1;
                if (r_hpos == BANK_POS_NAME0 || r_hpos == BANK_POS_NAME1 ||
                    r_hpos == BANK_POS_LAST) begin
                    res.word_out = i_word;
                end else begin
                    res.word_out = rev32(i_word);
                end
                if (r_hpos == BANK_POS_LEN) begin
                    n_rem = i_word;
                end
                if (r_hpos >= BANK_POS_LAST) begin
                    n_hpos  = '0;
                    n_short = (i_word == r_tag);
                    n_wc    = r_wc + t_word'(BANK_HEADER_WORDS) + r_rem;
                    if (r_rem[31] || r_rem == '0) begin
                        n_rem           = '0;
                        res.record_last = (n_wc >= r_rec_len);
                        n_phase         = res.record_last ? PH_REC : PH_BANK;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_hpos = r_hpos + 4'd1;
                end
            end
            PH_DATA: begin
                res.word_out = r_short ? rev16pair(i_word) : rev32(i_word);
                n_rem        = rem_dec;
                if (rem_dec == '0) begin
                    res.record_last = (r_wc >= r_rec_len);
                    n_phase         = res.record_last ? PH_REC : PH_BANK;
                end
            end
            default: begin
                res.in_header = 1'b1;
                if (r_hpos == REC_POS_NAME0 || r_hpos == REC_POS_NAME1) begin
                    res.word_out = i_word;
                end else if (r_hpos == REC_POS_SIG) begin
                    res.word_out = rev32(SIGNATURE);
                end else begin
                    res.word_out = rev32(i_word);
                end
                if (r_hpos >= REC_POS_LAST) begin
                    n_hpos    = '0;
                    n_rec_len = i_word;
                    n_wc      = '0;
                    if (i_word == '0) begin
                        res.record_last = 1'b1;
                        n_phase         = PH_REC;
                    end else begin
                        n_phase = PH_BANK;
                    end
                end else begin
                    n_hpos  = r_hpos + 4'd1;
                    n_phase = PH_REC;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= TAG_RESET;
        end else if (i_cfg_we) begin
            r_tag <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_REC;
            r_hpos    <= '0;
            r_rec_len <= '0;
            r_wc      <= '0;
            r_rem     <= '0;
            r_short   <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_hpos    <= n_hpos;
            r_rec_len <= n_rec_len;
            r_wc      <= n_wc;
            r_rem     <= n_rem;
            r_short   <= n_short;
        end
    end

    assign o_res        = res;
    assign o_stat.phase = r_phase;
    assign o_stat.hpos  = r_hpos;
endmodule

/* design/bres_out_stage.sv */
// Result register of the record endian swapper, driving the output channel.
// Depends on bres_pkg and bres_out_if.
module bres_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bres_pkg::t_result   i_res,
    output logic                o_adv,
    bres_out_if.source          o_out
);
    import bres_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_adv = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.word_out    = r_res.word_out;
    assign o_out.record_last = r_res.record_last;
    assign o_out.in_header   = r_res.in_header;
endmodule
